>>> hdl/assert_macros.svh
// Assertion macros for the RTL of the sector timing core.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies b in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// a implies b in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

>>> hdl/svst_pkg.sv
// Shared types, constants and functions of the SVPWM sector timing core.
// Depends on nothing; used by all modules under hdl.
`timescale 1ns / 1ps

package svst_pkg;

    localparam int SINE_DEPTH = 1024;
    localparam int PHASE_BITS = 32;
    localparam int IDX_W      = $clog2(SINE_DEPTH);
    localparam int IDX_SHIFT  = IDX_W + 1;

    localparam logic [63:0] PI_Q30     = 64'd3373259426;
    localparam logic [15:0] DIV3_RECIP = 16'd21846;

    // serial multiplier geometry
    localparam int MC_W = 33;
    localparam int ML_W = 17;
    localparam int PR_W = MC_W + ML_W;

    // wide dwell-time arithmetic
    localparam int T_W = 51;

    localparam logic [1:0] REG_PERIOD   = 2'd0;
    localparam logic [1:0] REG_PH_GAIN  = 2'd1;
    localparam logic [1:0] REG_AMP_GAIN = 2'd2;

    localparam logic [1:0] ZA_NONE = 2'd0;
    localparam logic [1:0] ZA_LOW  = 2'd1;
    localparam logic [1:0] ZA_HIGH = 2'd2;

    typedef logic [15:0] sine_tab_t [SINE_DEPTH];

    typedef struct packed {
        logic            start;
        logic [MC_W-1:0] mcand;
        logic [ML_W-1:0] mplier;
    } mul_req_t;

    typedef struct packed {
        logic            done;
        logic [PR_W-1:0] product;
    } mul_rsp_t;

    // Q15 sine of k*pi/(2*depth), eight-term integer Taylor series in Q30
    function automatic logic [15:0] sine_q15(input int k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        x    = (64'(k) * PI_Q30) / (2 * SINE_DEPTH);
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 6;   sum = sum - term;
        term = ((term * x2) >> 30) / 20;  sum = sum + term;
        term = ((term * x2) >> 30) / 42;  sum = sum - term;
        term = ((term * x2) >> 30) / 72;  sum = sum + term;
        term = ((term * x2) >> 30) / 110; sum = sum - term;
        term = ((term * x2) >> 30) / 156; sum = sum + term;
        term = ((term * x2) >> 30) / 210; sum = sum - term;
        r = (sum + 64'd16384) >> 15;
        return r[15:0];
    endfunction

    function automatic sine_tab_t build_sine();
        sine_tab_t tab;
        for (int k = 0; k < SINE_DEPTH; k++) begin
            tab[k] = sine_q15(k);
        end
        return tab;
    endfunction

    // table index of a fraction of sixty degrees: round(f*2*depth/3), limited
    function automatic logic [IDX_W-1:0] sine_index(input logic [PHASE_BITS:0] f);
        logic [PHASE_BITS+IDX_SHIFT+1:0] n;
        logic [IDX_SHIFT+1:0]            v;
        logic [IDX_SHIFT+17:0]           p;
        logic [IDX_SHIFT+1:0]            q;
        n = ({(IDX_SHIFT+1)'(0), f} << IDX_SHIFT)
            + ((PHASE_BITS+IDX_SHIFT+2)'(3) << (PHASE_BITS-1));
        v = n[PHASE_BITS+IDX_SHIFT+1:PHASE_BITS];
        p = {16'd0, v} * {(IDX_SHIFT+2)'(0), DIV3_RECIP};
        q = p[IDX_SHIFT+17:16];
        if (q >= (IDX_SHIFT+2)'(SINE_DEPTH)) begin
            return IDX_W'(SINE_DEPTH - 1);
        end
        return q[IDX_W-1:0];
    endfunction

    // switch pattern of active vector for a sector, bit2 = phase A
    function automatic logic [2:0] vec_pattern(input logic [2:0] s);
        case (s)
            3'd0:    return 3'd4;
            3'd1:    return 3'd6;
            3'd2:    return 3'd2;
            3'd3:    return 3'd3;
            3'd4:    return 3'd1;
            default: return 3'd5;
        endcase
    endfunction

    // half-up rounding of a Q31 count, zero below, saturating at 16 bits
    function automatic logic [15:0] round_q31(input logic signed [T_W-1:0] t);
        logic [T_W-1:0] r;
        if (t <= 0) begin
            return 16'd0;
        end
        r = (T_W'(t) + (T_W'(1) << 30)) >> 31;
        if (r > T_W'(65535)) begin
            return 16'hFFFF;
        end
        return r[15:0];
    endfunction

endpackage

>>> hdl/svst_serial_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on svst_pkg for operand widths and request/response structs.
`timescale 1ns / 1ps

module svst_serial_mul (
    input  logic               aclk,
    input  logic               aresetn,
    input  svst_pkg::mul_req_t req,
    output svst_pkg::mul_rsp_t rsp
);

    logic [svst_pkg::MC_W-1:0]         mc_reg;
    logic [svst_pkg::MC_W-1:0]         hi_reg;
    logic [svst_pkg::ML_W-1:0]         lo_reg;
    logic [$clog2(svst_pkg::ML_W)-1:0] cnt_reg;
    logic                              busy_reg;
    logic                              done_reg;
    logic [svst_pkg::MC_W:0]           sum;

    // add the multiplicand when the current multiplier bit is set
    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mc_reg} : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                mc_reg   <= req.mcand;
                hi_reg   <= '0;
                lo_reg   <= req.mplier;
            end else if (busy_reg) begin
                hi_reg <= sum[svst_pkg::MC_W:1];
                lo_reg <= {sum[0], lo_reg[svst_pkg::ML_W-1:1]};
                if (cnt_reg == ($clog2(svst_pkg::ML_W))'(svst_pkg::ML_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = {hi_reg, lo_reg};

endmodule

>>> hdl/svst_sine_rom.sv
// Quarter-wave sine ROM in Q15 with registered read data.
// Depends on svst_pkg for the table builder and depth.
`timescale 1ns / 1ps

module svst_sine_rom (
    input  logic                       aclk,
    input  logic [svst_pkg::IDX_W-1:0] addr,
    output logic [15:0]                data
);

    localparam svst_pkg::sine_tab_t ROM = svst_pkg::build_sine();

    logic [15:0] data_reg;

    // synchronous read
    always_ff @(posedge aclk) begin
        data_reg <= ROM[addr];
    end

    assign data = data_reg;

endmodule

>>> hdl/svst_seq.sv
// Item sequencer: phase accumulator, index, sector, dwell times, compares.
// Depends on svst_pkg, svst_serial_mul and svst_sine_rom.
`timescale 1ns / 1ps

module svst_seq (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] period_cnt,
    input  logic [31:0] phase_gain,
    input  logic [15:0] amp_gain,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [11:0] freq_in,
    input  logic [11:0] amp_in,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [44:0] res_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_MSTEP, S_MAMP, S_SECT, S_RD1, S_RD2, S_RD3,
        S_MPM, S_MT1, S_MT2, S_T0, S_RND
    } state_t;

    localparam int PB = svst_pkg::PHASE_BITS;
    localparam int TW = svst_pkg::T_W;

    state_t                      state_reg;
    logic                        seq_reg;
    logic [PB-1:0]               acc_reg;
    logic [11:0]                 amp_reg;
    logic [16:0]                 m_reg;
    logic [2:0]                  sect_reg;
    logic [svst_pkg::IDX_W-1:0]  idx1_reg;
    logic [svst_pkg::IDX_W-1:0]  idx2_reg;
    logic [15:0]                 s1_reg;
    logic [15:0]                 s2_reg;
    logic [32:0]                 pm_reg;
    logic [48:0]                 t1_reg;
    logic [48:0]                 t2_reg;
    logic signed [TW-1:0]        ta_reg;
    logic signed [TW-1:0]        tb_reg;
    logic                        res_valid_reg;
    logic [44:0]                 res_data_reg;

    svst_pkg::mul_req_t          mreq;
    svst_pkg::mul_rsp_t          mrsp;
    logic [svst_pkg::IDX_W-1:0]  rom_addr;
    logic [15:0]                 rom_data;

    logic [PB+2:0]               scaled;
    logic [PB:0]                 frac;
    logic [PB:0]                 frac_c;
    logic [19:0]                 m_raw;
    logic signed [TW-1:0]        t0_raw;
    logic signed [TW-1:0]        t0_clamp;
    logic [15:0]                 ca;
    logic [15:0]                 cb;
    logic [2:0]                  pat_first;
    logic [2:0]                  pat_second;
    logic [2:0]                  sect_next;
    logic                        drop_null;
    logic                        out_free;

    svst_serial_mul u_mul (.aclk(aclk), .aresetn(aresetn), .req(mreq), .rsp(mrsp));
    svst_sine_rom   u_rom (.aclk(aclk), .addr(rom_addr), .data(rom_data));

    // sector and angle inside it from the updated phase
    assign scaled = {1'b0, acc_reg, 2'b00} + {2'b00, acc_reg, 1'b0};
    assign frac   = {1'b0, scaled[PB-1:0]};
    assign frac_c = ({1'b1, {PB{1'b0}}}) - frac;
    assign m_raw  = mrsp.product[27:8];

    // zero-vector time, clamped when table rounding overshoots the period
    assign t0_raw   = $signed({{(TW-47){1'b0}}, period_cnt, 31'd0})
                    - $signed({2'b00, t1_reg}) - $signed({2'b00, t2_reg});
    assign t0_clamp = t0_raw[TW-1] ? '0 : t0_raw;

    assign ca         = svst_pkg::round_q31(ta_reg);
    assign cb         = svst_pkg::round_q31(tb_reg);
    assign sect_next  = (sect_reg == 3'd5) ? 3'd0 : sect_reg + 3'd1;
    assign pat_first  = svst_pkg::vec_pattern(sect_reg);
    assign pat_second = svst_pkg::vec_pattern(sect_next);
    assign drop_null  = (ca == 16'd0) || (cb == 16'd0);
    assign out_free   = !res_valid_reg || res_ready;

    assign rom_addr = (state_reg == S_RD1) ? idx1_reg : idx2_reg;

    // multiplier requests
    always_comb begin
        mreq = '0;
        unique case (state_reg)
            S_IDLE: begin
                mreq.start  = in_valid;
                mreq.mcand  = {1'b0, phase_gain};
                mreq.mplier = {5'd0, freq_in};
            end
            S_MSTEP: begin
                mreq.start  = mrsp.done;
                mreq.mcand  = {17'd0, amp_gain};
                mreq.mplier = {5'd0, amp_reg};
            end
            S_RD3: begin
                mreq.start  = 1'b1;
                mreq.mcand  = {17'd0, period_cnt};
                mreq.mplier = m_reg;
            end
            S_MPM: begin
                mreq.start  = mrsp.done;
                mreq.mcand  = mrsp.product[32:0];
                mreq.mplier = {1'b0, s1_reg};
            end
            S_MT1: begin
                mreq.start  = mrsp.done;
                mreq.mcand  = pm_reg;
                mreq.mplier = {1'b0, s2_reg};
            end
            default: mreq = '0;
        endcase
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            seq_reg       <= 1'b1;
            acc_reg       <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            // result valid: set on a new result, cleared on its transaction
            if (state_reg == S_RND && out_free) begin
                res_valid_reg <= 1'b1;
            end else if (res_valid_reg && res_ready) begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (in_valid) begin
                        amp_reg   <= amp_in;
                        seq_reg   <= !seq_reg;
                        state_reg <= S_MSTEP;
                    end
                end
                S_MSTEP: begin
                    if (mrsp.done) begin
                        acc_reg   <= acc_reg + mrsp.product[47:48-PB];
                        state_reg <= S_MAMP;
                    end
                end
                S_MAMP: begin
                    if (mrsp.done) begin
                        m_reg     <= (m_raw > 20'd65536) ? 17'h10000 : m_raw[16:0];
                        state_reg <= S_SECT;
                    end
                end
                S_SECT: begin
                    sect_reg  <= (scaled[PB+2:PB] > 3'd5) ? 3'd5 : scaled[PB+2:PB];
                    idx1_reg  <= svst_pkg::sine_index(frac_c);
                    idx2_reg  <= svst_pkg::sine_index(frac);
                    state_reg <= S_RD1;
                end
                S_RD1: state_reg <= S_RD2;
                S_RD2: begin
                    s1_reg    <= rom_data;
                    state_reg <= S_RD3;
                end
                S_RD3: begin
                    s2_reg    <= rom_data;
                    state_reg <= S_MPM;
                end
                S_MPM: begin
                    if (mrsp.done) begin
                        pm_reg    <= mrsp.product[32:0];
                        state_reg <= S_MT1;
                    end
                end
                S_MT1: begin
                    if (mrsp.done) begin
                        t1_reg    <= mrsp.product[48:0];
                        state_reg <= S_MT2;
                    end
                end
                S_MT2: begin
                    if (mrsp.done) begin
                        t2_reg    <= mrsp.product[48:0];
                        state_reg <= S_T0;
                    end
                end
                S_T0: begin
                    ta_reg    <= t0_clamp;
                    tb_reg    <= t0_clamp + $signed({2'b00, seq_reg ? t1_reg : t2_reg});
                    state_reg <= S_RND;
                end
                S_RND: begin
                    if (out_free) begin
                        res_data_reg  <= {seq_reg, sect_reg, drop_null,
                                          drop_null ? svst_pkg::ZA_NONE
                                              : (seq_reg ? svst_pkg::ZA_HIGH
                                                         : svst_pkg::ZA_LOW),
                                          seq_reg ? pat_second : pat_first,
                                          seq_reg ? pat_first : pat_second,
                                          cb, ca};
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

>>> hdl/svpwm_sector_timing_core.sv
// SVPWM sector timing core: configuration registers and stream ports.
// An input transaction yields a valid result after five passes of the
// bit-serial multiplier plus sector, ROM read and rounding steps.
// Items are taken one at a time; a stalled result holds the next item.
// Synchronous active-low reset: registers to defaults, phase 0, sequence bit 1.
// Depends on svst_pkg, svst_seq and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module svpwm_sector_timing_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [11:0] freq_reading, [23:12] amp_reading
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] compare_a, [31:16] compare_b, [34:32] pattern_at_a,
    // [37:35] pattern_at_b, [39:38] zero_action, [40] period_hold,
    // [43:41] sector_index, [44] up_sequence, [47:45] zero
    output logic [47:0] m_tdata
);

    logic [15:0] period_reg;
    logic [31:0] ph_gain_reg;
    logic [15:0] amp_gain_reg;
    logic [44:0] res_data;

    assign cfg_ready = 1'b1;

    // configuration writes; unknown index ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg   <= 16'd7000;
            ph_gain_reg  <= 32'd288692286;
            amp_gain_reg <= 16'd3687;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                svst_pkg::REG_PERIOD:   period_reg   <= cfg_data[15:0];
                svst_pkg::REG_PH_GAIN:  ph_gain_reg  <= cfg_data;
                svst_pkg::REG_AMP_GAIN: amp_gain_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    svst_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .period_cnt (period_reg),
        .phase_gain (ph_gain_reg),
        .amp_gain   (amp_gain_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .freq_in    (s_tdata[11:0]),
        .amp_in     (s_tdata[23:12]),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res_data   (res_data)
    );

    assign m_tdata = {3'b000, res_data};

    // one item in flight at a time
    `ASSERT_NEXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // sector stays within six
    `ASSERT_IMPL(a_sector, aclk, aresetn, m_tvalid, m_tdata[43:41] <= 3'd5)
    // dropped null states leave no zero action
    `ASSERT_IMPL(a_null, aclk, aresetn, m_tvalid && m_tdata[40], m_tdata[39:38] == 2'd0)

endmodule
